// ===== hw/rtl/sprite_row_rle_decoder_defines.svh =====
// -----------------------------------------------------------------------------
// Sprite row RLE decoder assertion macros
// Shared concurrent assertion forms used by the decoder top level.
// -----------------------------------------------------------------------------
`ifndef SPRITE_ROW_RLE_DECODER_DEFINES_SVH
`define SPRITE_ROW_RLE_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SRRD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SRRD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/srrd_pkg.sv =====
// -----------------------------------------------------------------------------
// Sprite row RLE decoder package
// Payload types, header field constants and controller/datapath interface.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srrd_pkg;

    localparam int BYTE_W     = 8;
    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int COUNT_W    = 6;
    localparam int SKIP_W     = 7;
    localparam int SKIP_BIT   = 7;
    localparam int REPEAT_BIT = 6;

    localparam logic [BYTE_W-1:0] WIDTH_RESET = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              row_start;
        logic [ROW_W-1:0]  row_number;
    } in_t;

    typedef struct packed {
        logic [COL_W-1:0]  pixel_x;
        logic [ROW_W-1:0]  pixel_y;
        logic [BYTE_W-1:0] color_index;
        logic              last_of_run;
    } out_t;

    typedef enum logic [1:0] {
        COL_HOLD,
        COL_CLEAR,
        COL_SKIP,
        COL_STEP
    } col_op_t;

    typedef struct packed {
        logic    load_row;
        col_op_t col_op;
        logic    run_load;
        logic    run_dec;
        logic    color_load;
        logic    emit;
        logic    emit_last;
        logic    emit_held_color;
    } cmd_t;

    typedef struct packed {
        logic out_valid;
        logic width_zero;
        logic hdr_skip;
        logic hdr_repeat;
        logic count_zero;
        logic skip_end;
        logic step_end;
        logic run_one;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srrd_ctrl.sv =====
// -----------------------------------------------------------------------------
// Sprite row RLE decoder controller
// Tracks the decode mode and sequences repeat runs over the output register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srrd_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_row_start,
    input  wire logic             m_ready,
    input  wire srrd_pkg::status_t status,
    output srrd_pkg::cmd_t        cmd
);

    typedef enum logic [1:0] {
        MODE_DONE,
        MODE_HEADER,
        MODE_REPEAT,
        MODE_LITERAL
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    mode_t  mode_eff;
    mode_t  mode_end_step;
    logic   slot_free;
    logic   accept;

    assign slot_free     = !status.out_valid || m_ready;
    assign s_ready       = (state_reg == ST_IDLE) && slot_free;
    assign accept        = s_valid && s_ready;
    assign mode_end_step = status.step_end ? MODE_DONE : MODE_HEADER;

    always_comb begin
        if (s_row_start) begin
            mode_eff = status.width_zero ? MODE_DONE : MODE_HEADER;
        end else begin
            mode_eff = mode_reg;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.col_op = srrd_pkg::COL_HOLD;
        state_next = state_reg;
        mode_next  = mode_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mode_next = mode_eff;
                    if (s_row_start) begin
                        cmd.load_row = 1'b1;
                        cmd.col_op   = srrd_pkg::COL_CLEAR;
                    end
                    unique case (mode_eff)
                        MODE_HEADER: begin
                            if (status.hdr_skip) begin
                                cmd.col_op = srrd_pkg::COL_SKIP;
                                mode_next  = status.skip_end ? MODE_DONE : MODE_HEADER;
                            end else begin
                                cmd.run_load = 1'b1;
                                if (!status.count_zero) begin
                                    mode_next = status.hdr_repeat ? MODE_REPEAT : MODE_LITERAL;
                                end
                            end
                        end
                        MODE_LITERAL: begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            cmd.col_op    = srrd_pkg::COL_STEP;
                            cmd.run_dec   = 1'b1;
                            if (status.run_one) begin
                                mode_next = mode_end_step;
                            end
                        end
                        MODE_REPEAT: begin
                            cmd.emit       = 1'b1;
                            cmd.emit_last  = status.run_one;
                            cmd.color_load = 1'b1;
                            cmd.col_op     = srrd_pkg::COL_STEP;
                            cmd.run_dec    = 1'b1;
                            if (status.run_one) begin
                                mode_next = mode_end_step;
                            end else begin
                                state_next = ST_RUN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (slot_free) begin
                    cmd.emit            = 1'b1;
                    cmd.emit_last       = status.run_one;
                    cmd.emit_held_color = 1'b1;
                    cmd.col_op          = srrd_pkg::COL_STEP;
                    cmd.run_dec         = 1'b1;
                    if (status.run_one) begin
                        mode_next  = mode_end_step;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_DONE;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/srrd_datapath.sv =====
// -----------------------------------------------------------------------------
// Sprite row RLE decoder datapath
// Column, row, run count, held color and width registers plus the pixel output register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srrd_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    input  wire logic [srrd_pkg::BYTE_W-1:0]     cfg_data,
    input  wire srrd_pkg::in_t                   s_data,
    input  wire logic                            m_ready,
    output logic                                 m_valid,
    output srrd_pkg::out_t                       m_data,
    input  wire srrd_pkg::cmd_t                  cmd,
    output srrd_pkg::status_t                    status
);

    logic [srrd_pkg::BYTE_W-1:0]  width_reg;
    logic [srrd_pkg::COL_W-1:0]   column_reg, column_next;
    logic [srrd_pkg::ROW_W-1:0]   row_reg;
    logic [srrd_pkg::COUNT_W-1:0] run_reg, run_next;
    logic [srrd_pkg::BYTE_W-1:0]  color_reg;
    logic                         out_valid_reg, out_valid_next;
    srrd_pkg::out_t               out_reg;

    logic [srrd_pkg::COL_W-1:0]   skip_base;
    logic [srrd_pkg::COL_W-1:0]   skip_sum;
    logic [srrd_pkg::COL_W-1:0]   step_sum;
    logic [srrd_pkg::COL_W-1:0]   width_ext;

    assign skip_base = s_data.row_start ? '0 : column_reg;
    assign skip_sum  = skip_base
                     + {{(srrd_pkg::COL_W-srrd_pkg::SKIP_W){1'b0}},
                        s_data.data_byte[srrd_pkg::SKIP_W-1:0]};
    assign step_sum  = column_reg + {{(srrd_pkg::COL_W-1){1'b0}}, 1'b1};
    assign width_ext = {{(srrd_pkg::COL_W-srrd_pkg::BYTE_W){1'b0}}, width_reg};

    assign status.out_valid  = out_valid_reg;
    assign status.width_zero = (width_reg == '0);
    assign status.hdr_skip   = s_data.data_byte[srrd_pkg::SKIP_BIT];
    assign status.hdr_repeat = s_data.data_byte[srrd_pkg::REPEAT_BIT];
    assign status.count_zero = (s_data.data_byte[srrd_pkg::COUNT_W-1:0] == '0);
    assign status.skip_end   = (skip_sum >= width_ext);
    assign status.step_end   = (step_sum >= width_ext);
    assign status.run_one    = (run_reg == {{(srrd_pkg::COUNT_W-1){1'b0}}, 1'b1});

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        unique case (cmd.col_op)
            srrd_pkg::COL_CLEAR: column_next = '0;
            srrd_pkg::COL_SKIP:  column_next = skip_sum;
            srrd_pkg::COL_STEP:  column_next = step_sum;
            default:             column_next = column_reg;
        endcase
    end

    always_comb begin
        if (cmd.run_load) begin
            run_next = s_data.data_byte[srrd_pkg::COUNT_W-1:0];
        end else if (cmd.run_dec) begin
            run_next = run_reg - {{(srrd_pkg::COUNT_W-1){1'b0}}, 1'b1};
        end else begin
            run_next = run_reg;
        end
    end

    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= srrd_pkg::WIDTH_RESET;
            column_reg    <= '0;
            row_reg       <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                width_reg <= cfg_data;
            end
            if (cmd.load_row) begin
                row_reg <= s_data.row_number;
            end
            column_reg    <= column_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.color_load) begin
            color_reg <= s_data.data_byte;
        end
        if (cmd.emit) begin
            out_reg.pixel_x     <= column_reg;
            out_reg.pixel_y     <= row_reg;
            out_reg.color_index <= cmd.emit_held_color ? color_reg : s_data.data_byte;
            out_reg.last_of_run <= cmd.emit_last;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sprite_row_rle_decoder.sv =====
// -----------------------------------------------------------------------------
// Sprite row RLE decoder
// Turns a sprite row's run-length byte stream into column/row/color pixels.
// -----------------------------------------------------------------------------
// A repeat color byte starts a run of 1 to 63 pixels, and the input is held
// for the rest of the run, since the single output register moves one pixel
// per cycle while m_ready holds. A new byte is taken while the last pixel
// waits, as soon as that pixel leaves in the same cycle. The user must write
// frame_width through the cfg channel, always ready, only while the block is
// idle; the block does not enforce it. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_row_rle_decoder_defines.svh"

module sprite_row_rle_decoder (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [srrd_pkg::BYTE_W-1:0] cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire srrd_pkg::in_t               s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output srrd_pkg::out_t                   m_data
);

    srrd_pkg::cmd_t    cmd;
    srrd_pkg::status_t status;

    assign cfg_ready = 1'b1;

    srrd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_row_start (s_data.row_start),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    srrd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

    `SRRD_ASSERT_IMP(a_emit_slot_free, aclk, aresetn,
        cmd.emit, (!m_valid || m_ready), "pixel emitted over a stalled one")
    `SRRD_ASSERT_IMP(a_stall_blocks_input, aclk, aresetn,
        (m_valid && !m_ready), !s_ready, "input taken while output stalled")
    `SRRD_ASSERT_NEXT(a_emit_shows, aclk, aresetn,
        cmd.emit, m_valid, "emitted pixel not presented")

endmodule

`default_nettype wire

// ===== sim/sprite_row_rle_decoder_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Sprite row RLE decoder testbench
// Walks a table of directed bytes (reset width, skips, zero counts, full
// repeat runs, row restarts, bytes outside a row), then random rows over
// several frame widths. Both channels idle at random. Every pixel is checked
// field by field against a table pixel or a behavioral decoder kept in step.
// -----------------------------------------------------------------------------

module sprite_row_rle_decoder_tb;

    import srrd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int PHASES        = 5;
    localparam int PHASE_BYTES   = 32;

    localparam logic [BYTE_W-1:0] HDR_SKIP   = 8'h80;
    localparam logic [BYTE_W-1:0] HDR_REPEAT = 8'h40;

    typedef enum logic [1:0] {
        ROW_DONE,
        ROW_HEADER,
        ROW_REPEAT,
        ROW_LITERAL
    } row_mode_t;

    typedef enum logic [1:0] {
        BY_MODEL,
        NO_PIXEL,
        ONE_PIXEL
    } row_check_t;

    typedef struct packed {
        in_t        stim;
        row_check_t how;
        out_t       pixel;
    } step_row_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [BYTE_W-1:0] cfg_data  = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_t               s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_t              m_data;

    logic [COL_W-1:0]   col_m   = '0;
    logic [ROW_W-1:0]   row_m   = '0;
    row_mode_t          mode_m  = ROW_DONE;
    logic [COUNT_W-1:0] run_m   = '0;
    logic [BYTE_W-1:0]  width_m = WIDTH_RESET;

    out_t decoded[$];
    out_t expected_pixels[$];
    out_t head_pixel;

    bit              calm        = 1'b0;
    bit              row_pending = 1'b0;
    logic [ROW_W-1:0] row_id     = '0;
    int              bytes_taken = 0;
    int              errors      = 0;
    int              cycles      = 0;
    int              drain_stall = 0;

    step_row_t directed [24] = '{
        '{'{8'h45, 1'b0, 8'h00}, NO_PIXEL, '0},
        '{'{HDR_SKIP | 8'd1, 1'b1, 8'h00}, NO_PIXEL, '0},
        '{'{HDR_REPEAT | 8'd3, 1'b0, 8'h00}, NO_PIXEL, '0},
        '{'{8'hFF, 1'b0, 8'h00}, BY_MODEL, '0},
        '{'{HDR_REPEAT, 1'b0, 8'h00}, NO_PIXEL, '0},
        '{'{8'h00, 1'b0, 8'h00}, NO_PIXEL, '0},
        '{'{8'h02, 1'b0, 8'h00}, NO_PIXEL, '0},
        '{'{8'h00, 1'b0, 8'h00}, ONE_PIXEL, '{9'd4, 8'd0, 8'h00, 1'b1}},
        '{'{8'hAB, 1'b0, 8'h00}, ONE_PIXEL, '{9'd5, 8'd0, 8'hAB, 1'b1}},
        '{'{HDR_REPEAT | 8'd63, 1'b0, 8'h00}, NO_PIXEL, '0},
        '{'{8'h5A, 1'b0, 8'h00}, BY_MODEL, '0},
        '{'{HDR_SKIP | 8'd127, 1'b0, 8'h00}, NO_PIXEL, '0},
        '{'{HDR_SKIP | 8'd127, 1'b0, 8'h00}, NO_PIXEL, '0},
        '{'{8'h01, 1'b0, 8'h00}, NO_PIXEL, '0},
        '{'{8'h3F, 1'b1, 8'hFF}, NO_PIXEL, '0},
        '{'{8'h11, 1'b0, 8'h5C}, ONE_PIXEL, '{9'd0, 8'd255, 8'h11, 1'b1}},
        '{'{8'h05, 1'b1, 8'h80}, NO_PIXEL, '0},
        '{'{8'h22, 1'b0, 8'h00}, ONE_PIXEL, '{9'd0, 8'd128, 8'h22, 1'b1}},
        '{'{HDR_SKIP | 8'd1, 1'b1, 8'h07}, NO_PIXEL, '0},
        '{'{HDR_REPEAT | 8'd1, 1'b0, 8'h00}, NO_PIXEL, '0},
        '{'{8'h80, 1'b0, 8'h00}, ONE_PIXEL, '{9'd1, 8'd7, 8'h80, 1'b1}},
        '{'{HDR_SKIP, 1'b0, 8'h00}, NO_PIXEL, '0},
        '{'{HDR_REPEAT | 8'd2, 1'b0, 8'h00}, NO_PIXEL, '0},
        '{'{8'h33, 1'b1, 8'h09}, NO_PIXEL, '0}
    };

    sprite_row_rle_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = int'($urandom_range(0, 99));
        if (r < 55) return 0;
        if (r < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    function automatic int pick_count(input int top);
        int r;
        r = int'($urandom_range(0, 19));
        if (r == 0) return 0;
        if (r == 1) return top;
        return int'($urandom_range(1, 8));
    endfunction

    function automatic void close_run();
        mode_m = (col_m >= {1'b0, width_m}) ? ROW_DONE : ROW_HEADER;
    endfunction

    // Returns 1 when the byte belongs to an open row; pixels land in decoded.
    function automatic bit decode_byte(input in_t b);
        bit taken;
        int k;
        out_t px;
        decoded.delete();
        if (b.row_start) begin
            row_m  = b.row_number;
            col_m  = '0;
            run_m  = '0;
            mode_m = (width_m == '0) ? ROW_DONE : ROW_HEADER;
        end
        taken = (mode_m != ROW_DONE);
        case (mode_m)
            ROW_HEADER: begin
                if (b.data_byte[SKIP_BIT]) begin
                    col_m = col_m + {2'b00, b.data_byte[SKIP_W-1:0]};
                    close_run();
                end else begin
                    run_m = b.data_byte[COUNT_W-1:0];
                    if (run_m != '0)
                        mode_m = b.data_byte[REPEAT_BIT] ? ROW_REPEAT : ROW_LITERAL;
                end
            end
            ROW_REPEAT: begin
                for (k = 0; k < int'(run_m); k++) begin
                    px = '{col_m + 9'(k), row_m, b.data_byte, k == int'(run_m) - 1};
                    decoded = {decoded, px};
                end
                col_m = col_m + {3'b000, run_m};
                run_m = '0;
                close_run();
            end
            ROW_LITERAL: begin
                px = '{col_m, row_m, b.data_byte, 1'b1};
                decoded = {decoded, px};
                col_m = col_m + 9'd1;
                run_m = run_m - 6'd1;
                if (run_m == '0)
                    close_run();
            end
            default: ;
        endcase
        return taken;
    endfunction

    task automatic send_byte(input in_t item, input row_check_t how, input out_t typed);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        void'(decode_byte(item));
        bytes_taken++;
        case (how)
            BY_MODEL:  expected_pixels = {expected_pixels, decoded};
            ONE_PIXEL: expected_pixels = {expected_pixels, typed};
            default: ;
        endcase
    endtask

    task automatic put_byte(input logic [BYTE_W-1:0] value);
        in_t item;
        item.data_byte  = value;
        item.row_start  = row_pending;
        item.row_number = row_pending ? row_id : 8'($urandom);
        if ($urandom_range(0, 15) == 0)
            item = 17'($urandom);
        row_pending = 1'b0;
        send_byte(item, BY_MODEL, '0);
    endtask

    task automatic random_row();
        int segs;
        int cnt;
        row_pending = 1'b1;
        row_id      = 8'($urandom);
        segs        = int'($urandom_range(1, 6));
        repeat (segs) begin
            case ($urandom_range(0, 2))
                0: put_byte(HDR_SKIP | 8'(pick_count(127)));
                1: begin
                    put_byte(HDR_REPEAT | 8'(pick_count(63)));
                    put_byte(8'($urandom));
                end
                default: begin
                    cnt = pick_count(63);
                    put_byte(8'(cnt));
                    repeat (cnt) put_byte(8'($urandom));
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_width(input logic [BYTE_W-1:0] w);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_m = w;
    endtask

    always @(posedge aclk) begin
        if (drain_stall > 0) begin
            m_ready <= 1'b0;
            drain_stall--;
        end else begin
            m_ready <= 1'b1;
            drain_stall = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel: x=%0d y=%0d color=%0d",
                       m_data.pixel_x, m_data.pixel_y, m_data.color_index);
                errors++;
            end else begin
                head_pixel = expected_pixels.pop_front();
                if (m_data.pixel_x !== head_pixel.pixel_x) begin
                    $error("pixel_x: expected %0d, got %0d", head_pixel.pixel_x, m_data.pixel_x);
                    errors++;
                end
                if (m_data.pixel_y !== head_pixel.pixel_y) begin
                    $error("pixel_y: expected %0d, got %0d", head_pixel.pixel_y, m_data.pixel_y);
                    errors++;
                end
                if (m_data.color_index !== head_pixel.color_index) begin
                    $error("color_index: expected %0d, got %0d",
                           head_pixel.color_index, m_data.color_index);
                    errors++;
                end
                if (m_data.last_of_run !== head_pixel.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d",
                           head_pixel.last_of_run, m_data.last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [BYTE_W-1:0] w;
        int goal;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_byte(directed[i].stim, directed[i].how, directed[i].pixel);

        goal = bytes_taken;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0:       w = 8'd1;
                1:       w = 8'd255;
                2:       w = 8'($urandom_range(2, 20));
                3:       w = 8'($urandom_range(1, 255));
                default: w = 8'($urandom_range(1, 8));
            endcase
            write_width(w);
            calm = ($urandom_range(0, 3) == 0);
            goal += PHASE_BYTES;
            while (bytes_taken < goal)
                random_row();
        end
        wait_drained();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
